FILE: hdl/tdf_pkg.sv
`default_nettype none

package tdf_pkg;

    localparam int C_PROB_FRAC_BITS = 15;
    localparam int C_OUT_FRAC_BITS  = 15;
    localparam int C_LANE_LAT       = 36;
    localparam int C_MIX_LAT        = 4;

    localparam logic [2:0] C_REG_RADIUS_01  = 3'd0;
    localparam logic [2:0] C_REG_RADIUS_02  = 3'd1;
    localparam logic [2:0] C_REG_RADIUS_12  = 3'd2;
    localparam logic [2:0] C_REG_EXCITATION = 3'd3;
    localparam logic [2:0] C_REG_EMISSION_0 = 3'd4;
    localparam logic [2:0] C_REG_EMISSION_1 = 3'd5;
    localparam logic [2:0] C_REG_EMISSION_2 = 3'd6;

    localparam logic [15:0] C_RADIUS_RESET     = 16'd12800;
    localparam logic [47:0] C_EXCITATION_RESET = 48'h0000_0000_8000;
    localparam logic [47:0] C_EMISSION_0_RESET = 48'h0000_0000_8000;
    localparam logic [47:0] C_EMISSION_1_RESET = 48'h0000_8000_0000;
    localparam logic [47:0] C_EMISSION_2_RESET = 48'h8000_0000_0000;

    typedef struct packed {
        logic [15:0] dist_01;
        logic [15:0] dist_02;
        logic [15:0] dist_12;
        logic        last_node;
    } t_in;

    typedef struct packed {
        logic [15:0] prob_ch0;
        logic [15:0] prob_ch1;
        logic [15:0] prob_ch2;
        logic        last_out;
    } t_out;

endpackage

`default_nettype wire

FILE: hdl/tdf_div.sv
`default_nettype none

module tdf_div #(
    parameter int NW  = 33,
    parameter int DW  = 16,
    parameter int QW  = 32,
    parameter int TGW = 1
) (
    input  wire logic           i_clk,
    input  wire logic [NW-1:0]  i_n,
    input  wire logic [DW-1:0]  i_d,
    input  wire logic [TGW-1:0] i_tag,
    output logic      [QW-1:0]  o_q,
    output logic      [TGW-1:0] o_tag
);

    logic [DW-1:0]  w_rem_in [QW];
    logic [QW-1:0]  w_low_in [QW];
    logic [QW-1:0]  w_quo_in [QW];
    logic [DW-1:0]  w_div_in [QW];
    logic [TGW-1:0] w_tag_in [QW];

    logic [DW-1:0]  r_rem [QW];
    logic [QW-1:0]  r_low [QW];
    logic [QW-1:0]  r_quo [QW];
    logic [DW-1:0]  r_div [QW];
    logic [TGW-1:0] r_tag [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0] w_trial;
        logic [DW:0] w_diff;
        logic        w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in[k] = DW'(i_n[NW-1:QW]);
            assign w_low_in[k] = i_n[QW-1:0];
            assign w_quo_in[k] = '0;
            assign w_div_in[k] = i_d;
            assign w_tag_in[k] = i_tag;
        end else begin : g_next
            assign w_rem_in[k] = r_rem[k-1];
            assign w_low_in[k] = r_low[k-1];
            assign w_quo_in[k] = r_quo[k-1];
            assign w_div_in[k] = r_div[k-1];
            assign w_tag_in[k] = r_tag[k-1];
        end

        assign w_trial = {w_rem_in[k], w_low_in[k][QW-1]};
        assign w_diff  = w_trial - {1'b0, w_div_in[k]};
        assign w_ge    = (w_trial >= {1'b0, w_div_in[k]});

        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_low[k] <= {w_low_in[k][QW-2:0], 1'b0};
            r_quo[k] <= {w_quo_in[k][QW-2:0], w_ge};
            r_div[k] <= w_div_in[k];
            r_tag[k] <= w_tag_in[k];
        end
    end

    assign o_q   = r_quo[QW-1];
    assign o_tag = r_tag[QW-1];

endmodule

`default_nettype wire

FILE: hdl/tdf_lane.sv
`default_nettype none

module tdf_lane #(
    parameter int P_FRAC_BITS = 15
) (
    input  wire logic                  i_clk,
    input  wire logic [15:0]           i_radius,
    input  wire logic [15:0]           i_dist,
    output logic      [P_FRAC_BITS+32:0] o_s
);

    localparam int SW = P_FRAC_BITS + 33;
    localparam logic [SW-1:0] L_SAT = {1'b1, {(SW-1){1'b0}}};

    logic [15:0] w_r0;
    logic [15:0] w_r;
    logic [31:0] w_q;

    logic [63:0] r_sq;
    logic [31:0] r_qd;
    logic [63:0] r_cu;
    logic        r_sat1;
    logic [63:0] r_sx;
    logic        r_sat2;
    logic [SW-1:0] r_s;

    assign w_r0 = (i_radius == 16'd0) ? 16'd1 : i_radius;
    assign w_r  = (i_dist == 16'd0) ? 16'd1 : i_dist;

    tdf_div #(
        .NW (33),
        .DW (16),
        .QW (32),
        .TGW(1)
    ) u_ratio_div (
        .i_clk(i_clk),
        .i_n  ({1'b0, w_r0, 16'd0}),
        .i_d  (w_r),
        .i_tag(1'b0),
        .o_q  (w_q),
        .o_tag()
    );

    always_ff @(posedge i_clk) begin
        r_sq   <= w_q * w_q;
        r_qd   <= w_q;
        r_cu   <= r_sq[47:16] * r_qd;
        r_sat1 <= |r_sq[63:48];
        r_sx   <= r_cu[47:16] * r_cu[47:16];
        r_sat2 <= r_sat1 | (|r_cu[63:48]);
        r_s    <= r_sat2 ? L_SAT : SW'(r_sx >> (32 - P_FRAC_BITS));
    end

    assign o_s = r_s;

endmodule

`default_nettype wire

FILE: hdl/tdf_mix.sv
`default_nettype none

module tdf_mix #(
    parameter int P_FRAC_BITS = 15
) (
    input  wire logic                     i_clk,
    input  wire logic [P_FRAC_BITS-1:0]   i_e01,
    input  wire logic [P_FRAC_BITS-1:0]   i_e02,
    input  wire logic [P_FRAC_BITS-1:0]   i_e12,
    input  wire logic [47:0]              i_exc,
    input  wire logic [47:0]              i_em0,
    input  wire logic [47:0]              i_em1,
    input  wire logic [47:0]              i_em2,
    output logic      [P_FRAC_BITS+36:0]  o_ch0,
    output logic      [P_FRAC_BITS+36:0]  o_ch1,
    output logic      [P_FRAC_BITS+36:0]  o_ch2,
    output logic      [P_FRAC_BITS+38:0]  o_tot
);

    localparam int F  = P_FRAC_BITS;
    localparam int EW = F + 19;
    localparam int CW = EW + 18;
    localparam int TW = CW + 2;
    localparam logic [F:0] L_ONE = {1'b1, {F{1'b0}}};

    logic [2*F:0]   r_p01;
    logic [2*F-1:0] r_p02;
    logic [F-1:0]   r_e01;
    logic [F-1:0]   r_e02;
    logic [F-1:0]   r_e12;

    logic [F:0] w_t00;
    logic [F:0] w_t01;
    logic [F:0] w_t02;
    logic [F:0] w_t11;
    logic [F:0] w_t12;
    logic [15:0] w_x0;
    logic [15:0] w_x1;
    logic [15:0] w_x2;
    logic [F+16:0] w_a00;
    logic [F+16:0] w_a01;
    logic [F+16:0] w_a11;
    logic [F+16:0] w_a02;
    logic [F+16:0] w_a12;

    logic [EW-1:0] r_emit0;
    logic [EW-1:0] r_emit1;
    logic [EW-1:0] r_emit2;

    logic [EW+15:0] w_m [3][3];
    logic [CW-1:0]  w_ch [3];

    logic [CW-1:0] r_ch [3];
    logic [CW-1:0] r_cho [3];
    logic [TW-1:0] r_tot;

    always_comb begin
        w_t00 = L_ONE - {1'b0, r_e01} - {1'b0, r_e02};
        w_t01 = (F+1)'(r_p01 >> F);
        w_t02 = (F+1)'(r_p02 >> F) + {1'b0, r_e02};
        w_t11 = L_ONE - {1'b0, r_e12};
        w_t12 = {1'b0, r_e12};
        w_x0  = i_exc[15:0];
        w_x1  = i_exc[31:16];
        w_x2  = i_exc[47:32];
        w_a00 = w_x0 * w_t00;
        w_a01 = w_x0 * w_t01;
        w_a11 = w_x1 * w_t11;
        w_a02 = w_x0 * w_t02;
        w_a12 = w_x1 * w_t12;
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        assign w_m[0][c] = i_em0[16*c +: 16] * r_emit0;
        assign w_m[1][c] = i_em1[16*c +: 16] * r_emit1;
        assign w_m[2][c] = i_em2[16*c +: 16] * r_emit2;
        assign w_ch[c]   = CW'(w_m[0][c]) + CW'(w_m[1][c]) + CW'(w_m[2][c]);
    end

    always_ff @(posedge i_clk) begin
        r_p01 <= i_e01 * (L_ONE - {1'b0, i_e12});
        r_p02 <= i_e01 * i_e12;
        r_e01 <= i_e01;
        r_e02 <= i_e02;
        r_e12 <= i_e12;

        r_emit0 <= EW'(w_a00);
        r_emit1 <= EW'(w_a01) + EW'(w_a11);
        r_emit2 <= EW'(w_a02) + EW'(w_a12) + EW'({w_x2, {F{1'b0}}});

        for (int c = 0; c < 3; c++) begin
            r_ch[c]  <= w_ch[c];
            r_cho[c] <= r_ch[c];
        end
        r_tot <= TW'(r_ch[0]) + TW'(r_ch[1]) + TW'(r_ch[2]);
    end

    assign o_ch0 = r_cho[0];
    assign o_ch1 = r_cho[1];
    assign o_ch2 = r_cho[2];
    assign o_tot = r_tot;

endmodule

`default_nettype wire

FILE: hdl/three_dye_fret_channel_probability_core.sv
`default_nettype none

// Three-dye FRET channel probabilities, one grid node per transaction. A node is
// taken on every clock edge with start high; busy is always low, so nodes may
// stream back to back at one per cycle. Each result passes through pipelined
// dividers: 32 stages for the distance ratio, P_FRAC_BITS stages for the
// transfer efficiencies and 16 for the normalisation, plus the multiply and
// mixing stages. The result stays on o_result for exactly one cycle with
// o_done high and must be captured then: the receiver cannot stall the
// pipeline. Write the configuration registers only while no node is in flight.
module three_dye_fret_channel_probability_core #(
    parameter int P_FRAC_BITS = tdf_pkg::C_PROB_FRAC_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire tdf_pkg::t_in  i_item,
    output logic               o_done,
    output tdf_pkg::t_out      o_result,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [5:0]    paddr,
    input  wire logic [63:0]   pwdata,
    output logic      [63:0]   prdata,
    output logic               pready
);

    import tdf_pkg::*;

    localparam int F   = P_FRAC_BITS;
    localparam int SW  = F + 33;
    localparam int DW  = SW + 1;
    localparam int CW  = F + 37;
    localparam int TW  = CW + 2;
    localparam int OQW = C_OUT_FRAC_BITS + 1;
    localparam int LAT = C_LANE_LAT + 1 + F + C_MIX_LAT + OQW + 1;
    localparam logic [DW-1:0] L_ONE = DW'({1'b1, {F{1'b0}}});

    logic [15:0] r_radius_01;
    logic [15:0] r_radius_02;
    logic [15:0] r_radius_12;
    logic [47:0] r_excitation;
    logic [47:0] r_emission_0;
    logic [47:0] r_emission_1;
    logic [47:0] r_emission_2;

    logic        w_wr;
    logic [2:0]  w_idx;
    logic        w_accept;

    logic [SW-1:0] w_s01;
    logic [SW-1:0] w_s02;
    logic [SW-1:0] w_s12;
    logic [SW-1:0] r_s01;
    logic [SW-1:0] r_s02;
    logic [SW-1:0] r_s12;
    logic [DW-1:0] r_den0;
    logic [DW-1:0] r_den1;
    logic [F-1:0]  w_e01;
    logic [F-1:0]  w_e02;
    logic [F-1:0]  w_e12;

    logic [CW-1:0] w_ch0;
    logic [CW-1:0] w_ch1;
    logic [CW-1:0] w_ch2;
    logic [TW-1:0] w_tot;
    logic [OQW-1:0] w_p0;
    logic [OQW-1:0] w_p1;
    logic [OQW-1:0] w_p2;
    logic           w_zero;

    logic [15:0] r_prob0;
    logic [15:0] r_prob1;
    logic [15:0] r_prob2;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_last;

    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign w_accept = start & ~busy;
    assign w_wr     = psel & penable & pwrite & pready;
    assign w_idx    = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_01  <= C_RADIUS_RESET;
            r_radius_02  <= C_RADIUS_RESET;
            r_radius_12  <= C_RADIUS_RESET;
            r_excitation <= C_EXCITATION_RESET;
            r_emission_0 <= C_EMISSION_0_RESET;
            r_emission_1 <= C_EMISSION_1_RESET;
            r_emission_2 <= C_EMISSION_2_RESET;
        end else if (w_wr) begin
            case (w_idx)
                C_REG_RADIUS_01:  r_radius_01  <= pwdata[15:0];
                C_REG_RADIUS_02:  r_radius_02  <= pwdata[15:0];
                C_REG_RADIUS_12:  r_radius_12  <= pwdata[15:0];
                C_REG_EXCITATION: r_excitation <= pwdata[47:0];
                C_REG_EMISSION_0: r_emission_0 <= pwdata[47:0];
                C_REG_EMISSION_1: r_emission_1 <= pwdata[47:0];
                C_REG_EMISSION_2: r_emission_2 <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            C_REG_RADIUS_01:  prdata = {48'd0, r_radius_01};
            C_REG_RADIUS_02:  prdata = {48'd0, r_radius_02};
            C_REG_RADIUS_12:  prdata = {48'd0, r_radius_12};
            C_REG_EXCITATION: prdata = {16'd0, r_excitation};
            C_REG_EMISSION_0: prdata = {16'd0, r_emission_0};
            C_REG_EMISSION_1: prdata = {16'd0, r_emission_1};
            C_REG_EMISSION_2: prdata = {16'd0, r_emission_2};
            default:          prdata = 64'd0;
        endcase
    end

    tdf_lane #(.P_FRAC_BITS(F)) u_lane_01 (
        .i_clk(i_clk), .i_radius(r_radius_01), .i_dist(i_item.dist_01), .o_s(w_s01)
    );
    tdf_lane #(.P_FRAC_BITS(F)) u_lane_02 (
        .i_clk(i_clk), .i_radius(r_radius_02), .i_dist(i_item.dist_02), .o_s(w_s02)
    );
    tdf_lane #(.P_FRAC_BITS(F)) u_lane_12 (
        .i_clk(i_clk), .i_radius(r_radius_12), .i_dist(i_item.dist_12), .o_s(w_s12)
    );

    always_ff @(posedge i_clk) begin
        r_s01  <= w_s01;
        r_s02  <= w_s02;
        r_s12  <= w_s12;
        r_den0 <= L_ONE + DW'(w_s01) + DW'(w_s02);
        r_den1 <= L_ONE + DW'(w_s12);
    end

    tdf_div #(.NW(SW+F), .DW(DW), .QW(F), .TGW(1)) u_eff_01 (
        .i_clk(i_clk), .i_n({r_s01, {F{1'b0}}}), .i_d(r_den0), .i_tag(1'b0),
        .o_q(w_e01), .o_tag()
    );
    tdf_div #(.NW(SW+F), .DW(DW), .QW(F), .TGW(1)) u_eff_02 (
        .i_clk(i_clk), .i_n({r_s02, {F{1'b0}}}), .i_d(r_den0), .i_tag(1'b0),
        .o_q(w_e02), .o_tag()
    );
    tdf_div #(.NW(SW+F), .DW(DW), .QW(F), .TGW(1)) u_eff_12 (
        .i_clk(i_clk), .i_n({r_s12, {F{1'b0}}}), .i_d(r_den1), .i_tag(1'b0),
        .o_q(w_e12), .o_tag()
    );

    tdf_mix #(.P_FRAC_BITS(F)) u_mix (
        .i_clk(i_clk),
        .i_e01(w_e01),
        .i_e02(w_e02),
        .i_e12(w_e12),
        .i_exc(r_excitation),
        .i_em0(r_emission_0),
        .i_em1(r_emission_1),
        .i_em2(r_emission_2),
        .o_ch0(w_ch0),
        .o_ch1(w_ch1),
        .o_ch2(w_ch2),
        .o_tot(w_tot)
    );

    tdf_div #(.NW(CW+C_OUT_FRAC_BITS), .DW(TW), .QW(OQW), .TGW(1)) u_norm_0 (
        .i_clk(i_clk), .i_n({w_ch0, {C_OUT_FRAC_BITS{1'b0}}}), .i_d(w_tot),
        .i_tag(w_tot == '0), .o_q(w_p0), .o_tag(w_zero)
    );
    tdf_div #(.NW(CW+C_OUT_FRAC_BITS), .DW(TW), .QW(OQW), .TGW(1)) u_norm_1 (
        .i_clk(i_clk), .i_n({w_ch1, {C_OUT_FRAC_BITS{1'b0}}}), .i_d(w_tot),
        .i_tag(1'b0), .o_q(w_p1), .o_tag()
    );
    tdf_div #(.NW(CW+C_OUT_FRAC_BITS), .DW(TW), .QW(OQW), .TGW(1)) u_norm_2 (
        .i_clk(i_clk), .i_n({w_ch2, {C_OUT_FRAC_BITS{1'b0}}}), .i_d(w_tot),
        .i_tag(1'b0), .o_q(w_p2), .o_tag()
    );

    always_ff @(posedge i_clk) begin
        r_prob0 <= w_zero ? 16'd0 : w_p0[15:0];
        r_prob1 <= w_zero ? 16'd0 : w_p1[15:0];
        r_prob2 <= w_zero ? 16'd0 : w_p2[15:0];
        r_last  <= {r_last[LAT-2:0], i_item.last_node};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    assign o_done = r_vld[LAT-1];

    always_comb begin
        o_result.prob_ch0 = r_prob0;
        o_result.prob_ch1 = r_prob1;
        o_result.prob_ch2 = r_prob2;
        o_result.last_out = r_last[LAT-1];
    end

endmodule

`default_nettype wire

FILE: sim/three_dye_fret_channel_probability_core_tb.sv
`default_nettype none

module three_dye_fret_channel_probability_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tdf_pkg::*;

    localparam int FB  = C_PROB_FRAC_BITS;
    localparam int LAT = 58 + FB;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    t_in           i_item = '0;
    logic          o_done;
    t_out          o_result;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [5:0]    paddr = '0;
    logic [63:0]   pwdata = '0;
    logic [63:0]   prdata;
    logic          pready;

    three_dye_fret_channel_probability_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    logic [15:0] rad01, rad02, rad12;
    logic [47:0] exc_word, em_row0, em_row1, em_row2;

    t_in  node_q[$];
    t_out prob_q[$];
    int   fail_count = 0;
    int   gap_pct = 0;
    bit   hold_nodes = 1'b0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic add_node(input t_in n);
        node_q = {node_q, n};
    endtask

    function automatic logic [63:0] frac_quot(input logic [63:0] a, input logic [63:0] b,
                                              input int fb);
        logic [63:0] q;
        logic [63:0] r;
        q = 0;
        r = a;
        if (r >= b) begin
            q = 1;
            r = r - b;
        end
        for (int k = 0; k < fb; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
                r = r - b;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] sixth_power(input logic [15:0] r0_in,
                                                input logic [15:0] d_in);
        logic [63:0] r0, d, q, q2, q3;
        r0 = (r0_in == 0) ? 64'd1 : 64'(r0_in);
        d  = (d_in == 0) ? 64'd1 : 64'(d_in);
        q  = (r0 << 16) / d;
        q2 = (q * q) >> 16;
        if (q2 >= 64'h1_0000_0000) return 64'd1 << (32 + FB);
        q3 = (q2 * q) >> 16;
        if (q3 >= 64'h1_0000_0000) return 64'd1 << (32 + FB);
        return (q3 * q3) >> (32 - FB);
    endfunction

    function automatic t_out channel_probs(input t_in n);
        logic [63:0] one, s01, s02, s12, e01, e02, e12, tot;
        logic [63:0] t[3][3];
        logic [63:0] emit[3];
        logic [63:0] ch[3];
        logic [47:0] rows[3];
        t_out r;
        one = 64'd1 << FB;
        s01 = sixth_power(rad01, n.dist_01);
        s02 = sixth_power(rad02, n.dist_02);
        s12 = sixth_power(rad12, n.dist_12);
        e01 = frac_quot(s01, one + s01 + s02, FB);
        e02 = frac_quot(s02, one + s01 + s02, FB);
        e12 = frac_quot(s12, one + s12, FB);
        t[0][0] = one - e01 - e02;
        t[0][1] = (e01 * (one - e12)) >> FB;
        t[0][2] = ((e01 * e12) >> FB) + e02;
        t[1][0] = 0;
        t[1][1] = one - e12;
        t[1][2] = e12;
        t[2][0] = 0;
        t[2][1] = 0;
        t[2][2] = one;
        rows[0] = em_row0;
        rows[1] = em_row1;
        rows[2] = em_row2;
        for (int d = 0; d < 3; d++) begin
            emit[d] = 0;
            for (int i = 0; i < 3; i++) emit[d] += 64'(exc_word[16*i +: 16]) * t[i][d];
        end
        tot = 0;
        for (int c = 0; c < 3; c++) begin
            ch[c] = 0;
            for (int d = 0; d < 3; d++) ch[c] += 64'(rows[d][16*c +: 16]) * emit[d];
            tot += ch[c];
        end
        r.prob_ch0 = (tot > 0) ? 16'(frac_quot(ch[0], tot, 15)) : 16'd0;
        r.prob_ch1 = (tot > 0) ? 16'(frac_quot(ch[1], tot, 15)) : 16'd0;
        r.prob_ch2 = (tot > 0) ? 16'(frac_quot(ch[2], tot, 15)) : 16'd0;
        r.last_out = n.last_node;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) prob_q = {prob_q, channel_probs(i_item)};
        if (!i_rst_n || hold_nodes || node_q.size() == 0 || $urandom_range(99) < gap_pct) begin
            if (!(start && busy)) start <= 1'b0;
        end else if (!(start && busy)) begin
            start  <= 1'b1;
            i_item <= node_q.pop_front();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_done) begin
            if (prob_q.size() == 0) begin
                report_mismatch("unexpected transaction", o_result.prob_ch0, 16'd0);
            end else begin
                want = prob_q.pop_front();
                if (o_result.prob_ch0 !== want.prob_ch0)
                    report_mismatch("prob_ch0", o_result.prob_ch0, want.prob_ch0);
                if (o_result.prob_ch1 !== want.prob_ch1)
                    report_mismatch("prob_ch1", o_result.prob_ch1, want.prob_ch1);
                if (o_result.prob_ch2 !== want.prob_ch2)
                    report_mismatch("prob_ch2", o_result.prob_ch2, want.prob_ch2);
                if (o_result.last_out !== want.last_out)
                    report_mismatch("last_out", 16'(o_result.last_out), 16'(want.last_out));
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx) << 3;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            C_REG_RADIUS_01:  rad01    = val[15:0];
            C_REG_RADIUS_02:  rad02    = val[15:0];
            C_REG_RADIUS_12:  rad12    = val[15:0];
            C_REG_EXCITATION: exc_word = val[47:0];
            C_REG_EMISSION_0: em_row0  = val[47:0];
            C_REG_EMISSION_1: em_row1  = val[47:0];
            default:          em_row2  = val[47:0];
        endcase
    endtask

    task automatic drain();
        while (node_q.size() != 0 || start || prob_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_dist();
        case ($urandom_range(5))
            0:       return 16'($urandom_range(3));
            1:       return 16'($urandom_range(65535, 65000));
            2:       return 16'($urandom_range(512));
            default: return 16'($urandom_range(20000, 4000));
        endcase
    endfunction

    function automatic t_in rand_node();
        t_in n;
        n.dist_01   = rand_dist();
        n.dist_02   = rand_dist();
        n.dist_12   = rand_dist();
        n.last_node = 1'($urandom);
        return n;
    endfunction

    function automatic logic [47:0] rand_lanes();
        logic [47:0] w;
        for (int k = 0; k < 3; k++)
            w[16*k +: 16] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
        return w;
    endfunction

    task automatic random_config();
        reg_write(C_REG_RADIUS_01, 64'($urandom));
        reg_write(C_REG_RADIUS_02, 64'($urandom_range(20000, 6000)));
        reg_write(C_REG_RADIUS_12, 64'($urandom_range(20000, 6000)));
        reg_write(C_REG_EXCITATION, {$urandom, $urandom});
        reg_write(C_REG_EMISSION_0, 64'(rand_lanes()));
        reg_write(C_REG_EMISSION_1, 64'(rand_lanes()));
        reg_write(C_REG_EMISSION_2, 64'(rand_lanes()));
    endtask

    initial begin
        t_in n;
        rad01 = C_RADIUS_RESET;
        rad02 = C_RADIUS_RESET;
        rad12 = C_RADIUS_RESET;
        exc_word = C_EXCITATION_RESET;
        em_row0 = C_EMISSION_0_RESET;
        em_row1 = C_EMISSION_1_RESET;
        em_row2 = C_EMISSION_2_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes at reset settings
        n = '{16'd0, 16'd0, 16'd0, 1'b0};             add_node(n);
        n = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};    add_node(n);
        n = '{16'd12800, 16'd12800, 16'd12800, 1'b0}; add_node(n);
        n = '{16'd1, 16'hFFFF, 16'd1, 1'b1};          add_node(n);
        n = '{16'hFFFF, 16'd0, 16'hFFFF, 1'b0};       add_node(n);
        n = '{16'h5555, 16'hAAAA, 16'h5555, 1'b1};    add_node(n);
        n = '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0};    add_node(n);
        drain();

        // zero and all-ones radii, all-ones lanes, zero total
        reg_write(C_REG_RADIUS_01, 64'd0);
        reg_write(C_REG_RADIUS_02, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(C_REG_RADIUS_12, 64'd0);
        reg_write(C_REG_EXCITATION, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(C_REG_EMISSION_0, 64'hFFFF_FFFF_FFFF);
        reg_write(C_REG_EMISSION_1, 64'hFFFF_FFFF_FFFF);
        reg_write(C_REG_EMISSION_2, 64'hFFFF_FFFF_FFFF);
        n = '{16'd0, 16'd0, 16'd0, 1'b1};             add_node(n);
        n = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};    add_node(n);
        n = '{16'd300, 16'd70, 16'd9000, 1'b1};       add_node(n);
        drain();
        reg_write(C_REG_EXCITATION, 64'd0);
        n = '{16'd100, 16'd200, 16'd300, 1'b1};       add_node(n);
        drain();
        reg_write(C_REG_EXCITATION, 64'h0000_8000_0000);
        reg_write(C_REG_EMISSION_0, 64'd0);
        reg_write(C_REG_EMISSION_1, 64'h0000_0000_8000);
        reg_write(C_REG_EMISSION_2, 64'd0);
        n = '{16'd1000, 16'd1000, 16'd0, 1'b0};       add_node(n);
        n = '{16'd1000, 16'd1000, 16'hFFFF, 1'b1};    add_node(n);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            gap_pct = (ph < 2) ? 9 : (ph < 4) ? 85 : 0;
            random_config();
            for (int k = 0; k < 90; k++) begin
                add_node(rand_node());
                if (k == 45) begin
                    while (node_q.size() != 0) @(posedge i_clk);
                    hold_nodes = 1'b1;
                    while (start || prob_q.size() != 0) @(posedge i_clk);
                    hold_nodes = 1'b0;
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("three_dye_fret_channel_probability_core test passed");
        end else begin
            $display("three_dye_fret_channel_probability_core test failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("three_dye_fret_channel_probability_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
